// File: sv/rpbc_pkg.sv
// rpbc_pkg: shared types, mode codes and arithmetic constants for the
// rgb pixel blend compositor. No dependencies.
package rpbc_pkg;

   // pixel and channel geometry
   localparam int unsigned PIX_W  = 24;
   localparam int unsigned CH_W   = 8;
   localparam int unsigned NUM_CH = 3;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [CH_W-1:0]  chan_type;

   // brightness sum r+g+b and lerp arithmetic widths
   localparam int unsigned SUM_W   = 10;
   localparam int unsigned PROD_W  = 18;
   localparam int unsigned RECIP_W = 21;
   localparam int unsigned QPROD_W = 39;
   localparam int unsigned MUL_W   = 16;

   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [QPROD_W-1:0] qprod_type;
   typedef logic [MUL_W-1:0]   mul_type;

   localparam sum_type SUM_MAX    = 10'd765;
   localparam sum_type THRESH_MAX = 10'd382;

   // ceil(2^30 / 765): floor(n * RECIP_765 >> 30) == floor(n / 765) for n < 2^18
   localparam logic [RECIP_W-1:0] RECIP_765   = 21'd1403585;
   localparam int unsigned        RECIP_SHIFT = 30;

   // source shaping codes
   typedef logic [1:0] blend_mode_type;
   localparam blend_mode_type BLEND_NONE   = 2'd0;
   localparam blend_mode_type BLEND_INVERT = 2'd1;
   localparam blend_mode_type BLEND_THRESH = 2'd2;
   localparam blend_mode_type BLEND_LERP   = 2'd3;

   // composite codes
   typedef logic [2:0] comp_mode_type;
   localparam comp_mode_type CMP_MAX     = 3'd0;
   localparam comp_mode_type CMP_MIN     = 3'd1;
   localparam comp_mode_type CMP_AVG     = 3'd2;
   localparam comp_mode_type CMP_MUL     = 3'd3;
   localparam comp_mode_type CMP_ADD     = 3'd4;
   localparam comp_mode_type CMP_SUB     = 3'd5;
   localparam comp_mode_type CMP_REPLACE = 3'd6;
   localparam comp_mode_type CMP_SPARE   = 3'd7;

   // register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_BLEND     = 3'd0;
   localparam csr_index_type CSR_COMPOSITE = 3'd1;
   localparam csr_index_type CSR_PRIMARY   = 3'd2;
   localparam csr_index_type CSR_SECONDARY = 3'd3;

   // floor(x / 255) for x up to 255 * 255, the largest channel product
   function automatic chan_type div255(input mul_type x);
      mul_type t;
      t = x + MUL_W'(x[MUL_W-1:CH_W]) + MUL_W'(1);
      return t[MUL_W-1:CH_W];
   endfunction

endpackage

// File: sv/rgb_pixel_blend_compositor_unit.sv
// rgb_pixel_blend_compositor_unit: seven-stage pipeline from an accepted req
// word to its rsp word, throughput one word per cycle while rsp_ready is high.
// The depth is set by the lerp path: brightness sum, two multiplies per
// channel, a reciprocal multiply for /765, then composite multiply and /255.
// Each stage holds its word under backpressure and bubbles are filled.
// Synchronous reset empties the pipeline and loads the register defaults.
module rgb_pixel_blend_compositor_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rpbc_pkg::pixel_type    req_target_pixel,
   input  rpbc_pkg::pixel_type    req_source_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rpbc_pkg::pixel_type    rsp_blended_pixel,
   input  logic                   csr_wr_en,
   input  rpbc_pkg::csr_index_type csr_index,
   input  rpbc_pkg::pixel_type    csr_wr_data
);
   import rpbc_pkg::*;

   localparam int unsigned NUM_STG = 7;

   // configuration registers
   blend_mode_type blend_mode_ff;
   comp_mode_type  composite_mode_ff;
   pixel_type      primary_color_ff;
   pixel_type      secondary_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff      <= BLEND_NONE;
         composite_mode_ff  <= CMP_ADD;
         primary_color_ff   <= '0;
         secondary_color_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BLEND:     blend_mode_ff      <= csr_wr_data[1:0];
            CSR_COMPOSITE: composite_mode_ff  <= csr_wr_data[2:0];
            CSR_PRIMARY:   primary_color_ff   <= csr_wr_data;
            CSR_SECONDARY: secondary_color_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // valid bits and per-stage load enables
   logic [NUM_STG-1:0] vld_ff;
   logic [NUM_STG-1:0] vld_in;
   logic [NUM_STG-1:0] en;

   always_comb begin
      en[NUM_STG-1] = !vld_ff[NUM_STG-1] || rsp_ready;
      for (int i = NUM_STG-2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in = {vld_ff[NUM_STG-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STG; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NUM_STG-1];

   // stage 1: brightness sum
   pixel_type tgt_s1_ff, src_s1_ff;
   sum_type   sum_s1_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         tgt_s1_ff <= req_target_pixel;
         src_s1_ff <= req_source_pixel;
         sum_s1_ff <= SUM_W'(req_source_pixel[7:0]) + SUM_W'(req_source_pixel[15:8])
                      + SUM_W'(req_source_pixel[23:16]);
      end
   end

   // stage 2: lerp weights, p*(765-S) and q*S per channel
   pixel_type tgt_s2_ff, src_s2_ff;
   sum_type   sum_s2_ff;
   prod_type  pw_s2_ff [NUM_CH];
   prod_type  qw_s2_ff [NUM_CH];
   sum_type   inv_sum;

   assign inv_sum = SUM_MAX - sum_s1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         tgt_s2_ff <= tgt_s1_ff;
         src_s2_ff <= src_s1_ff;
         sum_s2_ff <= sum_s1_ff;
         for (int k = 0; k < NUM_CH; k++) begin
            pw_s2_ff[k] <= PROD_W'(primary_color_ff[k*CH_W +: CH_W]) * PROD_W'(inv_sum);
            qw_s2_ff[k] <= PROD_W'(secondary_color_ff[k*CH_W +: CH_W]) * PROD_W'(sum_s1_ff);
         end
      end
   end

   // stage 3: lerp numerator
   pixel_type tgt_s3_ff, src_s3_ff;
   sum_type   sum_s3_ff;
   prod_type  num_s3_ff [NUM_CH];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         tgt_s3_ff <= tgt_s2_ff;
         src_s3_ff <= src_s2_ff;
         sum_s3_ff <= sum_s2_ff;
         for (int k = 0; k < NUM_CH; k++) begin
            num_s3_ff[k] <= pw_s2_ff[k] + qw_s2_ff[k];
         end
      end
   end

   // stage 4: divide by 765 through the reciprocal
   pixel_type tgt_s4_ff, src_s4_ff;
   sum_type   sum_s4_ff;
   qprod_type qp_s4_ff [NUM_CH];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         tgt_s4_ff <= tgt_s3_ff;
         src_s4_ff <= src_s3_ff;
         sum_s4_ff <= sum_s3_ff;
         for (int k = 0; k < NUM_CH; k++) begin
            qp_s4_ff[k] <= QPROD_W'(num_s3_ff[k]) * QPROD_W'(RECIP_765);
         end
      end
   end

   // stage 5: shaped source
   pixel_type tgt_s5_ff, shaped_s5_ff;
   pixel_type shaped_in;
   pixel_type lerp_pix;

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         lerp_pix[k*CH_W +: CH_W] = qp_s4_ff[k][RECIP_SHIFT +: CH_W];
      end
      unique case (blend_mode_ff)
         BLEND_NONE:   shaped_in = src_s4_ff;
         BLEND_INVERT: shaped_in = (src_s4_ff == '0) ? '0 : ~src_s4_ff;
         BLEND_THRESH: begin
            if (sum_s4_ff == '0) begin
               shaped_in = '0;
            end else if (sum_s4_ff <= THRESH_MAX) begin
               shaped_in = primary_color_ff;
            end else begin
               shaped_in = secondary_color_ff;
            end
         end
         BLEND_LERP:   shaped_in = (src_s4_ff == '0) ? '0 : lerp_pix;
         default:      shaped_in = src_s4_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         tgt_s5_ff    <= tgt_s4_ff;
         shaped_s5_ff <= shaped_in;
      end
   end

   // stage 6: per-channel composite, product kept for the /255 step
   pixel_type simple_in;
   pixel_type simple_s6_ff;
   mul_type   mul_s6_ff [NUM_CH];
   logic      is_mul_s6_ff;
   chan_type  ca, cb;
   logic [CH_W:0] csum;

   always_comb begin
      simple_in = '0;
      ca        = '0;
      cb        = '0;
      csum      = '0;
      for (int k = 0; k < NUM_CH; k++) begin
         ca   = tgt_s5_ff[k*CH_W +: CH_W];
         cb   = shaped_s5_ff[k*CH_W +: CH_W];
         csum = {1'b0, ca} + {1'b0, cb};
         case (composite_mode_ff) inside
            CMP_MAX: simple_in[k*CH_W +: CH_W] = (ca > cb) ? ca : cb;
            CMP_MIN: simple_in[k*CH_W +: CH_W] = (ca < cb) ? ca : cb;
            CMP_AVG: simple_in[k*CH_W +: CH_W] = csum[CH_W:1];
            CMP_ADD: simple_in[k*CH_W +: CH_W] = csum[CH_W] ? '1 : csum[CH_W-1:0];
            CMP_SUB: simple_in[k*CH_W +: CH_W] = (ca > cb) ? (ca - cb) : '0;
            CMP_REPLACE, CMP_SPARE:
               simple_in[k*CH_W +: CH_W] = (shaped_s5_ff != '0) ? cb : ca;
            default: simple_in[k*CH_W +: CH_W] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         simple_s6_ff <= simple_in;
         is_mul_s6_ff <= (composite_mode_ff == CMP_MUL);
         for (int k = 0; k < NUM_CH; k++) begin
            mul_s6_ff[k] <= MUL_W'(tgt_s5_ff[k*CH_W +: CH_W])
                            * MUL_W'(shaped_s5_ff[k*CH_W +: CH_W]);
         end
      end
   end

   // stage 7: output register, multiply mode scaled by /255
   pixel_type out_s7_ff;
   pixel_type out_in;

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         out_in[k*CH_W +: CH_W] = is_mul_s6_ff ? div255(mul_s6_ff[k])
                                               : simple_s6_ff[k*CH_W +: CH_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         out_s7_ff <= out_in;
      end
   end

   assign rsp_blended_pixel = out_s7_ff;

   // checks
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted word did not reach stage 1");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> sum_s1_ff <= SUM_MAX)
      else $error("brightness sum out of range");

   a_lerp_quot_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (qp_s4_ff[0][QPROD_W-1:RECIP_SHIFT+CH_W] == '0
                  && qp_s4_ff[1][QPROD_W-1:RECIP_SHIFT+CH_W] == '0
                  && qp_s4_ff[2][QPROD_W-1:RECIP_SHIFT+CH_W] == '0))
      else $error("lerp quotient exceeds channel range");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !rsp_ready |-> !req_ready)
      else $error("input taken while pipeline full and stalled");

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking testbench for rgb_pixel_blend_compositor_unit, with a
// scoreboard class that predicts each blended word and plain driver tasks.
// Depends on rpbc_pkg for pixel types, mode codes and register indexes.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rpbc_pkg::*;

   localparam int PIPE_LATENCY  = 7;
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int RANDOM_WORDS  = 1150;
   localparam pixel_type WHITE  = 24'hFF_FFFF;
   localparam pixel_type BLACK  = 24'h00_0000;

   // blend predictor and store of pending blended words
   class pixel_blend_scoreboard;
      blend_mode_type blend_reg     = BLEND_NONE;
      comp_mode_type  comp_reg      = CMP_ADD;
      pixel_type      primary_reg   = '0;
      pixel_type      secondary_reg = '0;
      pixel_type      pending_pixels[$];
      int             errors        = 0;

      function void set_register(csr_index_type idx, pixel_type data);
         case (idx)
            CSR_BLEND:     blend_reg     = data[1:0];
            CSR_COMPOSITE: comp_reg      = data[2:0];
            CSR_PRIMARY:   primary_reg   = data;
            CSR_SECONDARY: secondary_reg = data;
            default: ;
         endcase
      endfunction

      // reshape the source under the blend mode
      function pixel_type shape_source(pixel_type src);
         int        level;
         int        p;
         int        q;
         int        num;
         int        k;
         pixel_type res;
         level = int'(src[7:0]) + int'(src[15:8]) + int'(src[23:16]);
         res   = '0;
         case (blend_reg)
            BLEND_NONE: res = src;
            BLEND_INVERT: begin
               if (src != '0) res = ~src;
            end
            BLEND_THRESH: begin
               if (level != 0) res = (2 * level < int'(SUM_MAX)) ? primary_reg : secondary_reg;
            end
            default: begin
               if (src != '0) begin
                  for (k = 0; k < NUM_CH; k++) begin
                     p   = int'(primary_reg[8*k +: 8]);
                     q   = int'(secondary_reg[8*k +: 8]);
                     num = p * int'(SUM_MAX) + (q - p) * level;
                     res[8*k +: 8] = chan_type'(num / int'(SUM_MAX));
                  end
               end
            end
         endcase
         return res;
      endfunction

      // join target and shaped source channel by channel
      function pixel_type combine(pixel_type tgt, pixel_type src);
         int        a;
         int        b;
         int        v;
         int        k;
         pixel_type res;
         if (comp_reg == CMP_REPLACE || comp_reg == CMP_SPARE) return (src != '0) ? src : tgt;
         res = '0;
         for (k = 0; k < NUM_CH; k++) begin
            a = int'(tgt[8*k +: 8]);
            b = int'(src[8*k +: 8]);
            case (comp_reg)
               CMP_MAX: v = (a > b) ? a : b;
               CMP_MIN: v = (a < b) ? a : b;
               CMP_AVG: v = (a + b) / 2;
               CMP_MUL: v = (a * b) / 255;
               CMP_ADD: v = (a + b > 255) ? 255 : a + b;
               default: v = (a > b) ? a - b : 0;
            endcase
            res[8*k +: 8] = chan_type'(v);
         end
         return res;
      endfunction

      function void note_input(pixel_type tgt, pixel_type src);
         pending_pixels.insert(pending_pixels.size(), combine(tgt, shape_source(src)));
      endfunction

      function void check_result(pixel_type actual);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            $error("blended_pixel: no word pending, actual %06h", actual);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (actual !== want) begin
               $error("blended_pixel: expected %06h, actual %06h", want, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction
   endclass

   logic          clock             = 1'b0;
   logic          reset             = 1'b1;
   logic          req_valid         = 1'b0;
   logic          req_ready;
   pixel_type     req_target_pixel  = '0;
   pixel_type     req_source_pixel  = '0;
   logic          rsp_valid;
   logic          rsp_ready         = 1'b1;
   pixel_type     rsp_blended_pixel;
   logic          csr_wr_en         = 1'b0;
   csr_index_type csr_index         = CSR_BLEND;
   pixel_type     csr_wr_data       = '0;

   pixel_blend_scoreboard blend_sb = new();

   int cycle_count = 0;
   int burst_left  = 0;
   int rx_style    = 0;
   int rx_left     = 0;
   int rx_stall    = 0;
   int rx_tick     = 0;
   int words_sent  = 0;
   int phase_words = 0;
   int i;

   rgb_pixel_blend_compositor_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_pixel  (req_target_pixel),
      .req_source_pixel  (req_source_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_blended_pixel (rsp_blended_pixel),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // accepted req words feed the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) blend_sb.note_input(req_target_pixel, req_source_pixel);
   end

   // accepted rsp words are checked
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) blend_sb.check_result(rsp_blended_pixel);
   end

   // receiver stall pattern: free, coin toss, periodic, or long stalls
   always @(negedge clock) begin : rx_pattern
      logic nxt;
      if (rx_left == 0) begin
         rx_style = $urandom_range(0, 3);
         rx_left  = $urandom_range(20, 200);
      end
      rx_left--;
      rx_tick++;
      case (rx_style)
         0: nxt = 1'b1;
         1: nxt = 1'($urandom_range(0, 1));
         2: nxt = (rx_tick % 4 != 3);
         default: begin
            if (rx_stall > 0) begin
               rx_stall--;
               nxt = 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               rx_stall = $urandom_range(1, 12);
               nxt      = 1'b0;
            end else begin
               nxt = 1'b1;
            end
         end
      endcase
      rsp_ready <= nxt;
   end

   // one req word, then a random gap once the burst is used up
   task automatic send_word(input pixel_type tgt, input pixel_type src);
      int gap;
      req_target_pixel <= tgt;
      req_source_pixel <= src;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 20);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // drop valid and wait for every pending word to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (blend_sb.pending() != 0) @(negedge clock);
   endtask

   // write all four registers, junk above the field bits, plus a stray index
   task automatic set_modes(input blend_mode_type bm, input comp_mode_type cm,
                            input pixel_type prim, input pixel_type sec);
      pixel_type     data;
      csr_index_type idx;
      data       = pixel_type'($urandom());
      data[1:0]  = bm;
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_BLEND;
      csr_wr_data <= data;
      blend_sb.set_register(CSR_BLEND, data);
      @(negedge clock);
      data       = pixel_type'($urandom());
      data[2:0]  = cm;
      csr_index   <= CSR_COMPOSITE;
      csr_wr_data <= data;
      blend_sb.set_register(CSR_COMPOSITE, data);
      @(negedge clock);
      csr_index   <= CSR_PRIMARY;
      csr_wr_data <= prim;
      blend_sb.set_register(CSR_PRIMARY, prim);
      @(negedge clock);
      csr_index   <= CSR_SECONDARY;
      csr_wr_data <= sec;
      blend_sb.set_register(CSR_SECONDARY, sec);
      @(negedge clock);
      // index past the last register must be ignored
      idx  = csr_index_type'($urandom_range(int'(CSR_SECONDARY) + 1, int'(csr_index_type'('1))));
      data = pixel_type'($urandom());
      csr_index   <= idx;
      csr_wr_data <= data;
      blend_sb.set_register(idx, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // pixel whose channel sum is the given value
   function automatic pixel_type pixel_with_sum(int level);
      int r;
      int g;
      int rest;
      r    = $urandom_range((level > 510) ? level - 510 : 0, (level < 255) ? level : 255);
      rest = level - r;
      g    = $urandom_range((rest > 255) ? rest - 255 : 0, (rest < 255) ? rest : 255);
      return {8'(rest - g), 8'(g), 8'(r)};
   endfunction

   function automatic pixel_type pick_color();
      case ($urandom_range(0, 4))
         0: return BLACK;
         1: return WHITE;
         default: return pixel_type'($urandom());
      endcase
   endfunction

   function automatic pixel_type pick_source();
      case ($urandom_range(0, 9))
         0: return BLACK;
         1: return WHITE;
         2: return pixel_with_sum($urandom_range(378, 387));
         3: return {{8{1'($urandom())}}, {8{1'($urandom())}}, {8{1'($urandom())}}};
         default: return pixel_type'($urandom());
      endcase
   endfunction

   function automatic pixel_type pick_target();
      case ($urandom_range(0, 7))
         0: return BLACK;
         1: return WHITE;
         default: return pixel_type'($urandom());
      endcase
   endfunction

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults: no shaping, saturating add
      send_word(BLACK, BLACK);
      send_word(WHITE, WHITE);
      send_word(24'h80_40_C0, 24'h90_10_50);
      wait_drained();

      // invert, with zero staying zero, and replace if nonzero
      set_modes(BLEND_INVERT, CMP_REPLACE, BLACK, BLACK);
      send_word(24'h12_34_56, BLACK);
      send_word(24'h65_43_21, WHITE);
      send_word(24'hAB_CD_EF, 24'h0F_F0_01);
      wait_drained();

      // threshold either side of the half-brightness boundary, with max
      set_modes(BLEND_THRESH, CMP_MAX, 24'h12_34_56, 24'hFE_DC_BA);
      send_word(24'h20_20_20, 24'h80_7F_7F);
      send_word(24'h20_20_20, 24'h80_80_7F);
      send_word(24'h77_88_99, BLACK);
      send_word(BLACK, WHITE);
      wait_drained();

      // lerp black to white, spare composite code acts as replace
      set_modes(BLEND_LERP, CMP_SPARE, BLACK, WHITE);
      send_word(24'h5A_A5_3C, BLACK);
      send_word(24'h5A_A5_3C, WHITE);
      send_word(24'h5A_A5_3C, 24'h01_00_00);
      wait_drained();

      // lerp white to black with multiply
      set_modes(BLEND_LERP, CMP_MUL, WHITE, BLACK);
      send_word(WHITE, 24'h40_80_C0);
      send_word(24'hFF_80_01, 24'h01_01_01);
      wait_drained();

      // remaining composite modes on an unshaped source
      set_modes(BLEND_NONE, CMP_MIN, BLACK, BLACK);
      send_word(24'hFF_00_80, 24'h00_FF_7F);
      send_word(WHITE, BLACK);
      wait_drained();
      set_modes(BLEND_NONE, CMP_SUB, BLACK, BLACK);
      send_word(24'hFF_00_80, 24'h00_FF_7F);
      send_word(WHITE, WHITE);
      wait_drained();
      set_modes(BLEND_NONE, CMP_AVG, BLACK, BLACK);
      send_word(24'hFF_01_80, 24'hFE_00_7F);
      send_word(WHITE, WHITE);
      wait_drained();

      // random phases, each under a fresh register setting
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         set_modes(blend_mode_type'($urandom_range(int'(BLEND_NONE), int'(BLEND_LERP))),
                   comp_mode_type'($urandom_range(int'(CMP_MAX), int'(CMP_SPARE))),
                   pick_color(), pick_color());
         phase_words = $urandom_range(10, 90);
         for (i = 0; i < phase_words; i++) send_word(pick_target(), pick_source());
         wait_drained();
      end

      repeat (4 * PIPE_LATENCY) @(negedge clock);
      if (blend_sb.errors == 0 && blend_sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/rpbc_pkg.sv
sv/rgb_pixel_blend_compositor_unit.sv
verif/tb_top.sv
